// ----- src/acs_pkg.sv -----
`timescale 1ns / 1ps
package acs_pkg;

  localparam int TEXT_ROWS = 4;
  localparam int TEXT_MAX = 27;
  localparam int BUTTON_BYTES = 2;
  localparam int HOST_CONTROL_BYTES = 30;
  localparam int TL_W = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;

  // register indexes
  localparam logic [1:0] REG_WAIT_LIMIT = 2'd0;
  localparam logic [1:0] REG_REPORT_INTERVAL = 2'd1;
  localparam logic [1:0] REG_STANDARD_TARGET = 2'd2;
  localparam logic [1:0] REG_EXTENDED_TARGET = 2'd3;

  // commands
  localparam logic [3:0] CMD_TICK = 4'd0;
  localparam logic [3:0] CMD_DISPLAY = 4'd1;
  localparam logic [3:0] CMD_TUNING = 4'd2;
  localparam logic [3:0] CMD_PRESENT = 4'd3;
  localparam logic [3:0] CMD_REFRESH = 4'd4;
  localparam logic [3:0] CMD_SETUP = 4'd5;
  localparam logic [3:0] CMD_DSTATE = 4'd6;
  localparam logic [3:0] CMD_TEXT = 4'd7;
  localparam logic [3:0] CMD_CLOSE = 4'd8;
  localparam logic [3:0] CMD_R1 = 4'd9;
  localparam logic [3:0] CMD_R2 = 4'd10;
  localparam logic [3:0] CMD_R4 = 4'd11;
  localparam logic [3:0] CMD_R5 = 4'd12;
  localparam logic [3:0] CMD_R6 = 4'd13;
  localparam logic [3:0] CMD_HOST = 4'd14;
  localparam logic [3:0] CMD_NONE = 4'd15;

  // transport result codes
  localparam logic [1:0] RES_BUSY = 2'd0;
  localparam logic [1:0] RES_DONE = 2'd1;
  localparam logic [1:0] RES_ERROR = 2'd2;
  localparam logic [1:0] RES_BAD = 2'd3;

  // pending flag bits
  localparam int F_GLYPHS = 0;
  localparam int F_DISPLAY = 1;
  localparam int F_CLOSE = 2;
  localparam int F_HC_PEND = 3;
  localparam int F_HC_READY = 4;
  localparam int F_PRESENT = 5;
  localparam int F_TUNING = 6;
  localparam int F_REFRESH = 7;
  localparam int F_SETUP = 8;
  localparam int F_DSTATE = 9;
  localparam int F_STAT_OK = 10;
  localparam int F_R1 = 11;
  localparam int F_R2 = 12;
  localparam int F_R4 = 13;
  localparam int F_R5 = 14;
  localparam int F_R6 = 15;
  localparam int F_DUE = 16;
  localparam int NFLAGS = 17;

  typedef enum logic [3:0] {
    PH_DISCOVER = 4'd0,
    PH_READY    = 4'd1,
    PH_PROBE    = 4'd2,
    PH_STATUS   = 4'd3,
    PH_BUTTONS  = 4'd4,
    PH_AXES     = 4'd5,
    PH_ROTARY   = 4'd6,
    PH_HOST     = 4'd7,
    PH_DSTATE   = 4'd8,
    PH_WRITE    = 4'd9
  } phase_t;

  typedef struct packed {
    logic [3:0]  command;
    logic        transport_owned;
    logic [1:0]  poll_result;
    logic [1:0]  queue_result;
    logic [15:0] argument;
    logic [7:0]  text_length;
    logic [7:0]  response_first;
    logic [7:0]  response_second;
  } item_t;

  typedef struct packed {
    logic        request_issued;
    logic        request_is_write;
    logic [7:0]  request_target;
    logic [7:0]  request_offset;
    logic [4:0]  request_length;
    logic        command_accepted;
    logic        endpoint_select;
    logic        connected;
    logic [7:0]  status_flags;
    logic [7:0]  motion_delta;
    logic        discovery_restarted;
  } result_t;

  typedef struct packed {
    logic [15:0] wait_limit;
    logic [3:0]  report_interval;
    logic [7:0]  standard_target;
    logic [7:0]  extended_target;
  } cfg_t;

endpackage

// ----- src/adapter_command_scheduler.sv -----
`timescale 1ns / 1ps
// Command scheduler for a two-endpoint polled adapter. Each input word is a
// run tick or a set-up command (command code on in_tuser); each gives exactly
// one result word, in the next cycle. An input word is taken every cycle while
// the output register is free or being drained, so the sustained rate is one
// word per clock; the scheduling decision is a single priority encode between
// the input port and the output register. Configuration writes are taken at
// any time but must only be issued while the block is idle.
module adapter_command_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command
  input  logic [3:0]  in_tuser,
  // transport_owned, poll_result, queue_result, argument, text_length,
  // response_first, response_second (zero pad to 48 bits)
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // request_issued, request_is_write, request_target, request_offset,
  // request_length, command_accepted, endpoint_select, connected,
  // status_flags, motion_delta, discovery_restarted (zero pad to 48 bits)
  output logic [47:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  acs_pkg::cfg_t    cfg;
  acs_pkg::item_t   item;
  acs_pkg::result_t res;
  acs_pkg::result_t out_r;
  logic             ovalid_r;
  logic             step;

  assign in_tready = !ovalid_r || out_tready;
  assign step = in_tvalid && in_tready;

  assign item.command = in_tuser;
  assign item.transport_owned = in_tdata[0];
  assign item.poll_result = in_tdata[2:1];
  assign item.queue_result = in_tdata[4:3];
  assign item.argument = in_tdata[20:5];
  assign item.text_length = in_tdata[28:21];
  assign item.response_first = in_tdata[36:29];
  assign item.response_second = in_tdata[44:37];

  acs_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
  );

  acs_core u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .item(item), .cfg(cfg), .res(res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (step) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_r <= res;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {
    5'd0,
    out_r.discovery_restarted,
    out_r.motion_delta,
    out_r.status_flags,
    out_r.connected,
    out_r.endpoint_select,
    out_r.command_accepted,
    out_r.request_length,
    out_r.request_offset,
    out_r.request_target,
    out_r.request_is_write,
    out_r.request_issued
  };

endmodule

// ----- src/acs_cfg_regs.sv -----
`timescale 1ns / 1ps
module acs_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output acs_pkg::cfg_t cfg
);

  acs_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wait_limit <= 16'd500;
      cfg_r.report_interval <= 4'd5;
      cfg_r.standard_target <= 8'h15;
      cfg_r.extended_target <= 8'h16;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        acs_pkg::REG_WAIT_LIMIT: cfg_r.wait_limit <= cfg_data;
        acs_pkg::REG_REPORT_INTERVAL: cfg_r.report_interval <= cfg_data[3:0];
        acs_pkg::REG_STANDARD_TARGET: cfg_r.standard_target <= cfg_data[7:0];
        acs_pkg::REG_EXTENDED_TARGET: cfg_r.extended_target <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- src/acs_core.sv -----
`timescale 1ns / 1ps
module acs_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  acs_pkg::item_t   item,
  input  acs_pkg::cfg_t    cfg,
  output acs_pkg::result_t res
);

  localparam int TL = acs_pkg::TEXT_ROWS;
  localparam int TW = acs_pkg::TL_W;

  logic                        ep_r, ep_nxt;
  acs_pkg::phase_t             ph_r, ph_nxt;
  logic [2:0]                  pin_r, pin_nxt;
  logic [acs_pkg::NFLAGS-1:0]  pf_r, pf_nxt;
  logic [TL-1:0]               tlp_r, tlp_nxt;
  logic [7:0]                  poff_r, poff_nxt;
  logic [3:0]                  cad_r, cad_nxt;
  logic [15:0]                 wc_r, wc_nxt;
  logic [7:0]                  fl_r, fl_nxt;
  logic [7:0]                  dl_r, dl_nxt;
  logic                        con_r, con_nxt;
  logic [4:0]                  tlen_mem [TL];

  logic        issued, is_wr, acc, rst_disc;
  logic [7:0]  off;
  logic [4:0]  len;
  logic        qok, rep, due;
  logic [TW-1:0] tsel;
  logic        twr;
  logic [TW-1:0] twr_idx;
  logic [15:0] am1;
  logic [7:0]  sv;

  assign am1 = item.argument - 16'd1;
  assign qok = item.queue_result == acs_pkg::RES_DONE;

  // lowest pending text line
  always_comb begin
    tsel = TW'(TL - 1);
    for (int i = TL - 2; i >= 0; i--) begin
      if (tlp_r[i]) tsel = TW'(i);
    end
  end

  always_comb begin
    ep_nxt = ep_r; ph_nxt = ph_r; pin_nxt = pin_r; pf_nxt = pf_r;
    tlp_nxt = tlp_r; poff_nxt = poff_r; cad_nxt = cad_r; wc_nxt = wc_r;
    fl_nxt = fl_r; dl_nxt = dl_r; con_nxt = con_r;
    issued = 1'b0; is_wr = 1'b0; off = 8'd0; len = 5'd0;
    acc = 1'b0; rst_disc = 1'b0; twr = 1'b0;
    twr_idx = am1[TW-1:0];
    rep = 1'b0; due = pf_r[acs_pkg::F_DUE]; sv = 8'd0;

    unique case (item.command)
      acs_pkg::CMD_TICK: begin
        if (ph_r != acs_pkg::PH_DISCOVER && ph_r != acs_pkg::PH_READY) begin
          // outstanding request: poll it
          if (item.poll_result == acs_pkg::RES_BUSY) begin
            if (wc_r >= cfg.wait_limit) rst_disc = 1'b1;
            else wc_nxt = wc_r + 16'd1;
          end else if (item.poll_result != acs_pkg::RES_DONE) begin
            rst_disc = 1'b1;
          end else begin
            wc_nxt = 16'd0;
            ph_nxt = acs_pkg::PH_READY;
            unique case (ph_r)
              acs_pkg::PH_PROBE: begin
                sv = ep_r ? (item.response_first & 8'h3f) : item.response_first;
                con_nxt = sv != 8'd0;
              end
              acs_pkg::PH_STATUS: begin
                fl_nxt = item.response_first;
                if (!item.response_first[7]) begin
                  pin_nxt = pin_r | item.response_first[2:0];
                  if (item.response_first[4]) pf_nxt[acs_pkg::F_HC_PEND] = 1'b1;
                  if (item.response_first[5]) pf_nxt[acs_pkg::F_GLYPHS] = 1'b1;
                end
                if (item.response_second[2]) dl_nxt = dl_r + 8'd1;
                else if (item.response_second[3]) dl_nxt = dl_r - 8'd1;
                pf_nxt[acs_pkg::F_STAT_OK] = 1'b1;
              end
              acs_pkg::PH_BUTTONS: pin_nxt[0] = 1'b0;
              acs_pkg::PH_AXES: pin_nxt[1] = 1'b0;
              acs_pkg::PH_ROTARY: pin_nxt[2] = 1'b0;
              acs_pkg::PH_HOST: begin
                pf_nxt[acs_pkg::F_HC_PEND] = 1'b0;
                pf_nxt[acs_pkg::F_HC_READY] = 1'b1;
              end
              default: ;
            endcase
          end
        end else if (item.transport_owned) begin
          if (item.poll_result == acs_pkg::RES_DONE) begin
            // priority selection of the next request
            is_wr = 1'b1;
            if (ph_r == acs_pkg::PH_DISCOVER) begin
              is_wr = 1'b0; off = 8'h0c; len = ep_r ? 5'd4 : 5'd1;
              ph_nxt = acs_pkg::PH_PROBE;
            end else if (pin_r[0]) begin
              is_wr = 1'b0; off = 8'h01; len = 5'(acs_pkg::BUTTON_BYTES);
              ph_nxt = acs_pkg::PH_BUTTONS;
            end else if (pin_r[1]) begin
              is_wr = 1'b0; off = 8'h02; len = 5'd2; ph_nxt = acs_pkg::PH_AXES;
            end else if (pin_r[2]) begin
              is_wr = 1'b0; off = 8'h03; len = ep_r ? 5'd2 : 5'd1;
              ph_nxt = acs_pkg::PH_ROTARY;
            end else if (pf_r[acs_pkg::F_HC_PEND] && !pf_r[acs_pkg::F_HC_READY]) begin
              is_wr = 1'b0; off = 8'ha0; len = 5'(acs_pkg::HOST_CONTROL_BYTES);
              ph_nxt = acs_pkg::PH_HOST;
            end else if (pf_r[acs_pkg::F_PRESENT] && ep_r) begin
              off = poff_r; len = 5'd0; ph_nxt = acs_pkg::PH_WRITE;
              if (qok) pf_nxt[acs_pkg::F_PRESENT] = 1'b0;
            end else if (pf_r[acs_pkg::F_TUNING]) begin
              off = 8'h0e; len = 5'd1; ph_nxt = acs_pkg::PH_WRITE;
              if (qok) pf_nxt[acs_pkg::F_TUNING] = 1'b0;
            end else if (pf_r[acs_pkg::F_REFRESH]) begin
              off = 8'h17; len = 5'd1; ph_nxt = acs_pkg::PH_WRITE;
              if (qok) pf_nxt[acs_pkg::F_REFRESH] = 1'b0;
            end else if (pf_r[acs_pkg::F_SETUP]) begin
              off = 8'hc0; len = 5'd1; ph_nxt = acs_pkg::PH_WRITE;
              if (qok) pf_nxt[acs_pkg::F_SETUP] = 1'b0;
            end else if (pf_r[acs_pkg::F_DSTATE] && !ep_r && pf_r[acs_pkg::F_STAT_OK]) begin
              off = 8'h18; len = 5'd1; ph_nxt = acs_pkg::PH_DSTATE;
              if (qok) pf_nxt[acs_pkg::F_DSTATE] = 1'b0;
            end else if (pf_r[acs_pkg::F_GLYPHS]) begin
              off = 8'h06; len = 5'd3; ph_nxt = acs_pkg::PH_WRITE;
              if (qok) pf_nxt[acs_pkg::F_GLYPHS] = 1'b0;
            end else if (pf_r[acs_pkg::F_DISPLAY] && !ep_r) begin
              off = 8'h0f; len = 5'd3; ph_nxt = acs_pkg::PH_WRITE;
              if (qok) pf_nxt[acs_pkg::F_DISPLAY] = 1'b0;
            end else if (tlp_r != '0 && ep_r) begin
              off = 8'h1a; len = tlen_mem[tsel]; ph_nxt = acs_pkg::PH_WRITE;
              if (qok) tlp_nxt[tsel] = 1'b0;
            end else if (pf_r[acs_pkg::F_CLOSE] && ep_r) begin
              off = 8'h1a; len = 5'd4; ph_nxt = acs_pkg::PH_WRITE;
              if (qok) pf_nxt[acs_pkg::F_CLOSE] = 1'b0;
            end else begin
              // report cadence
              rep = ep_r ? (pf_r[acs_pkg::F_R4] | pf_r[acs_pkg::F_R5] | pf_r[acs_pkg::F_R6])
                         : (pf_r[acs_pkg::F_R1] | pf_r[acs_pkg::F_R2]);
              due = pf_r[acs_pkg::F_DUE];
              if (rep && !due) begin
                if (cad_r == 4'd0) due = 1'b1;
                cad_nxt = cad_r + 4'd1;
                if (cad_nxt == cfg.report_interval) cad_nxt = 4'd0;
              end
              pf_nxt[acs_pkg::F_DUE] = due;
              ph_nxt = acs_pkg::PH_WRITE;
              if (due && !ep_r && pf_r[acs_pkg::F_R2]) begin
                off = 8'h04; len = 5'd18;
                if (qok) begin
                  pf_nxt[acs_pkg::F_R2] = 1'b0;
                  pf_nxt[acs_pkg::F_DUE] = pf_r[acs_pkg::F_R1];
                end
              end else if (due && !ep_r && pf_r[acs_pkg::F_R1]) begin
                off = 8'h05; len = 5'd12;
                if (qok) begin
                  pf_nxt[acs_pkg::F_R1] = 1'b0;
                  pf_nxt[acs_pkg::F_DUE] = pf_r[acs_pkg::F_R2];
                end
              end else if (due && ep_r && pf_r[acs_pkg::F_R4]) begin
                off = 8'h08; len = 5'd25;
                if (qok) begin
                  pf_nxt[acs_pkg::F_R4] = 1'b0;
                  pf_nxt[acs_pkg::F_DUE] = pf_r[acs_pkg::F_R5] | pf_r[acs_pkg::F_R6];
                end
              end else if (due && ep_r && pf_r[acs_pkg::F_R5]) begin
                off = 8'h09; len = 5'd16;
                if (qok) begin
                  pf_nxt[acs_pkg::F_R5] = 1'b0;
                  pf_nxt[acs_pkg::F_DUE] = pf_r[acs_pkg::F_R4] | pf_r[acs_pkg::F_R6];
                end
              end else if (due && ep_r && pf_r[acs_pkg::F_R6]) begin
                off = 8'h19; len = 5'd2;
                if (qok) begin
                  pf_nxt[acs_pkg::F_R6] = 1'b0;
                  pf_nxt[acs_pkg::F_DUE] = pf_r[acs_pkg::F_R4] | pf_r[acs_pkg::F_R5];
                end
              end else begin
                is_wr = 1'b0; off = 8'h00; len = 5'd2; ph_nxt = acs_pkg::PH_STATUS;
              end
            end
            if (qok) begin
              issued = 1'b1;
              wc_nxt = 16'd0;
            end else begin
              ph_nxt = ph_r;
              tlp_nxt = tlp_r;
              is_wr = 1'b0; off = 8'd0; len = 5'd0;
              // only the due flag and cadence survive a refused queue
              pf_nxt = pf_r;
              pf_nxt[acs_pkg::F_DUE] = due;
              if (item.queue_result != acs_pkg::RES_BUSY) rst_disc = 1'b1;
            end
          end else if (item.poll_result != acs_pkg::RES_BUSY) begin
            rst_disc = 1'b1;
          end
        end
      end
      acs_pkg::CMD_DISPLAY: if (item.argument != 16'd0) begin
        pf_nxt[acs_pkg::F_DISPLAY] = 1'b1; acc = 1'b1;
      end
      acs_pkg::CMD_TUNING: begin pf_nxt[acs_pkg::F_TUNING] = 1'b1; acc = 1'b1; end
      acs_pkg::CMD_PRESENT: if (item.argument >= 16'd1 && item.argument <= 16'd3) begin
        poff_nxt = 8'h20 + am1[7:0];
        pf_nxt[acs_pkg::F_PRESENT] = 1'b1; acc = 1'b1;
      end
      acs_pkg::CMD_REFRESH: begin pf_nxt[acs_pkg::F_REFRESH] = 1'b1; acc = 1'b1; end
      acs_pkg::CMD_SETUP: if (item.argument != 16'd0) begin
        pf_nxt[acs_pkg::F_SETUP] = 1'b1; acc = 1'b1;
      end
      acs_pkg::CMD_DSTATE: if (item.argument != 16'd0) begin
        pf_nxt[acs_pkg::F_DSTATE] = 1'b1; acc = 1'b1;
      end
      acs_pkg::CMD_TEXT: begin
        if (item.argument >= 16'd1 && item.argument <= 16'(TL)
            && item.text_length <= 8'(acs_pkg::TEXT_MAX)) begin
          twr = 1'b1;
          tlp_nxt[twr_idx] = 1'b1;
          acc = 1'b1;
        end
      end
      acs_pkg::CMD_CLOSE: begin pf_nxt[acs_pkg::F_CLOSE] = 1'b1; acc = 1'b1; end
      acs_pkg::CMD_R1: begin pf_nxt[acs_pkg::F_R1] = 1'b1; acc = 1'b1; end
      acs_pkg::CMD_R2: begin pf_nxt[acs_pkg::F_R2] = 1'b1; acc = 1'b1; end
      acs_pkg::CMD_R4: begin pf_nxt[acs_pkg::F_R4] = 1'b1; acc = 1'b1; end
      acs_pkg::CMD_R5: begin pf_nxt[acs_pkg::F_R5] = 1'b1; acc = 1'b1; end
      acs_pkg::CMD_R6: begin pf_nxt[acs_pkg::F_R6] = 1'b1; acc = 1'b1; end
      acs_pkg::CMD_HOST: if (pf_r[acs_pkg::F_HC_READY]) begin
        pf_nxt[acs_pkg::F_HC_READY] = 1'b0; acc = 1'b1;
      end
      default: ;
    endcase

    // discovery restart on the other endpoint
    if (rst_disc) begin
      pf_nxt = '0;
      pf_nxt[acs_pkg::F_DSTATE] = pf_r[acs_pkg::F_DSTATE] || ph_r == acs_pkg::PH_DSTATE;
      ep_nxt = ~ep_r;
      pin_nxt = 3'd0; tlp_nxt = '0; cad_nxt = 4'd0; wc_nxt = 16'd0;
      ph_nxt = acs_pkg::PH_DISCOVER;
      fl_nxt = 8'd0; dl_nxt = 8'd0; con_nxt = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ep_r <= 1'b0; ph_r <= acs_pkg::PH_DISCOVER; pin_r <= 3'd0; pf_r <= '0;
      tlp_r <= '0; poff_r <= 8'd0; cad_r <= 4'd0; wc_r <= 16'd0;
      fl_r <= 8'd0; dl_r <= 8'd0; con_r <= 1'b0;
    end else if (step) begin
      ep_r <= ep_nxt; ph_r <= ph_nxt; pin_r <= pin_nxt; pf_r <= pf_nxt;
      tlp_r <= tlp_nxt; poff_r <= poff_nxt; cad_r <= cad_nxt; wc_r <= wc_nxt;
      fl_r <= fl_nxt; dl_r <= dl_nxt; con_r <= con_nxt;
    end
  end

  // text record lengths
  always_ff @(posedge clk) begin
    if (step && twr) tlen_mem[twr_idx] <= item.text_length[4:0] + 5'd3;
  end

  always_comb begin
    res.request_issued = issued;
    res.request_is_write = is_wr;
    res.request_target = issued ? (ep_r ? cfg.extended_target : cfg.standard_target) : 8'd0;
    res.request_offset = off;
    res.request_length = len;
    res.command_accepted = acc;
    res.endpoint_select = ep_nxt;
    res.connected = con_nxt;
    res.status_flags = fl_nxt;
    res.motion_delta = dl_nxt;
    res.discovery_restarted = rst_disc;
  end

endmodule
